// File: hdl/lrukv_pkg.sv
// lrukv_pkg: item types, command struct and constants for the lru key/value cache
// used by lrukv_ctrl, lrukv_dp and lru_key_value_cache_top; no dependencies
package lrukv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [KEY_W-1:0] lookup_key;
    logic signed [VAL_W-1:0] put_value;
  } in_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } out_t;

  typedef struct packed {
    logic capture;
    logic look;
    logic update;
  } cmd_t;

endpackage

// File: hdl/lru_key_value_cache_top.sv
// lru key/value cache: 1 to MAX_ENTRIES fully associative entries with lru replacement
// result registered by the update step, which follows the lookup step and waits while out_stall holds the output
// a new item is taken only when idle, or in the update step of the previous item with the output free
// reset: synchronous, clears valid bits, recency ranks, entry count; capacity returns to 16
// key and value storage hold undefined data until written; there is no clearing pass
// depends on lrukv_pkg, lrukv_ctrl, lrukv_dp
module lru_key_value_cache_top
  import lrukv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lrukv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lrukv_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_item (out_item)
  );

endmodule

// File: hdl/lrukv_ctrl.sv
// lrukv_ctrl: sequencer for capture, lookup and update steps plus output handshake
// depends on lrukv_pkg
module lrukv_ctrl
  import lrukv_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   can_take;

  assign out_free = !out_valid_r || !out_stall;
  assign can_take = (state_r == S_IDLE) || ((state_r == S_UPD) && out_free);

  assign in_stall    = !can_take;
  assign out_valid   = out_valid_r;
  assign cmd.capture = can_take && in_valid;
  assign cmd.look    = (state_r == S_LOOK);
  assign cmd.update  = (state_r == S_UPD) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (out_free) state_nxt = in_valid ? S_LOOK : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_look_then_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |=> (state_r == S_UPD))
    else $error("lookup step not followed by update step");

  a_update_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> out_valid_r)
    else $error("update did not present a result");

  a_capture_then_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_LOOK))
    else $error("captured item not looked up");
`endif

endmodule

// File: hdl/lrukv_dp.sv
// lrukv_dp: key compare lanes, recency ranks, value memory and result register
// depends on lrukv_pkg; driven by commands from lrukv_ctrl
module lrukv_dp
  import lrukv_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  input  in_t              in_item,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  output out_t             out_item
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int WW = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0]        cap_r;
  logic [CW-1:0]           count_r;
  in_t                     req_r;
  logic [MAX_ENTRIES-1:0]  valid_r;
  logic signed [KEY_W-1:0] key_r  [MAX_ENTRIES];
  logic [IW-1:0]           rank_r [MAX_ENTRIES];
  logic [VAL_W-1:0]        val_mem [MAX_ENTRIES];
  logic [VAL_W-1:0]        rdata_r;

  logic                    hit_r;
  logic                    fresh_r;
  logic                    evict_r;
  logic [IW-1:0]           slot_r;
  logic [IW-1:0]           prom_rank_r;
  out_t                    out_r;

  logic [MAX_ENTRIES-1:0]  match;
  logic [MAX_ENTRIES-1:0]  lru_vec;
  logic                    hit;
  logic [IW-1:0]           hit_idx;
  logic [IW-1:0]           hit_rank;
  logic [IW-1:0]           lru_idx;
  logic [IW-1:0]           last_rank;
  logic [WW-1:0]           eff_cap;
  logic                    room;
  logic                    do_rank;

  assign last_rank = IW'(count_r - 1'b1);

  always_comb begin
    eff_cap = WW'(cap_r);
    if (cap_r == '0) eff_cap = WW'(1);
    if (eff_cap > WW'(MAX_ENTRIES)) eff_cap = WW'(MAX_ENTRIES);
  end

  assign room = WW'(count_r) < eff_cap;

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    lru_idx  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i]   = valid_r[i] && (key_r[i] == req_r.lookup_key);
      lru_vec[i] = valid_r[i] && (rank_r[i] == last_rank);
      if (match[i]) begin
        hit_idx  = hit_idx | IW'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (lru_vec[i]) lru_idx = lru_idx | IW'(i);
    end
  end

  assign hit = |match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_data;
    end
  end

  // lookup step results
  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= in_item;
    if (cmd.look) begin
      hit_r   <= hit;
      fresh_r <= (req_r.action == ACT_PUT) && !hit && room;
      evict_r <= (req_r.action == ACT_PUT) && !hit && !room;
      if (hit) begin
        slot_r <= hit_idx;
      end else if (room) begin
        slot_r <= IW'(count_r);
      end else begin
        slot_r <= lru_idx;
      end
      prom_rank_r <= hit ? hit_rank : last_rank;
      rdata_r     <= val_mem[hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (req_r.action == ACT_PUT)) begin
      val_mem[slot_r] <= req_r.put_value;
    end
  end

  assign do_rank = hit_r || fresh_r || evict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) rank_r[i] <= '0;
    end else if (cmd.update) begin
      if (fresh_r) begin
        valid_r[slot_r] <= 1'b1;
        count_r         <= count_r + 1'b1;
      end
      if (do_rank) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (IW'(i) == slot_r) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (fresh_r || (rank_r[i] < prom_rank_r))) begin
            rank_r[i] <= rank_r[i] + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && (fresh_r || evict_r)) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IW'(i) == slot_r) key_r[i] <= req_r.lookup_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_r.hit     <= hit_r;
      out_r.evicted <= evict_r;
      if (req_r.action == ACT_PUT) begin
        out_r.read_value <= req_r.put_value;
      end else if (hit_r) begin
        out_r.read_value <= rdata_r;
      end else begin
        out_r.read_value <= '1;
      end
    end
  end

  assign out_item = out_r;

`ifndef SYNTHESIS
  a_fresh_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && fresh_r) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert into free slot did not grow entry count");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && evict_r) |=> $stable(count_r))
    else $error("eviction changed entry count");

  a_get_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.update && (req_r.action == ACT_GET)) |=> $stable(count_r))
    else $error("get changed entry count");
`endif

endmodule
